// ----- rtl/bb3_pkg.sv -----
// Shared types, widths and constants of the 3x3 box blur stream.
package bb3_pkg;

    // Field widths of the pixel, result and configuration ports.
    localparam int PIX_W      = 8;
    localparam int BLUR_W     = 7;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int IMG_W_BITS = 12;
    localparam int IMG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Default size limits of the frame.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values, before clamping to the size limits.
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;

    // Arithmetic: a column sum of three pixels, a window sum of nine, and the
    // reciprocal of 25 in 16 fractional bits, exact for every window sum.
    localparam int CSUM_W      = 10;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 12;
    localparam logic [RECIP_W-1:0] RECIP = 12'd2622;
    localparam int RECIP_SHIFT = 16;

    // Depth of the job queue between the front and back parts.
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } bb3_reg_t;

    // Bit positions in a job's result mask, in emission order.
    localparam int RES_DIAG  = 0;  // pixel above and to the left
    localparam int RES_ABOVE = 1;  // pixel above, at a row end
    localparam int RES_LEFT  = 2;  // pixel to the left, in the last row
    localparam int RES_HERE  = 3;  // this pixel, closing the frame
    localparam int RES_N     = 4;

    // One classified input pixel: the results it causes and their payload.
    typedef struct packed {
        logic [BLUR_W-1:0] value;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [RES_N-1:0]  mask;
    } bb3_job_t;

endpackage

// ----- rtl/bb3_front.sv -----
// Front part: accepts pixels, keeps counters, line store and window, builds jobs.
module bb3_front #(
    parameter int  MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [bb3_pkg::PIX_W-1:0] pixel,
    output logic                     full,
    input  logic [WW-1:0]            wm1,
    input  logic [HW-1:0]            hm1,
    input  logic [bb3_pkg::QCW-1:0]  q_count,
    output logic                     job_push,
    output bb3_pkg::bb3_job_t        job
);
    import bb3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [RES_N-1:0] mask;
        logic             interior;
    } meta_t;

    logic             accept;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_end, frame_end;
    meta_t            cls;

    // Line store: older row in the upper byte, newer row in the lower byte.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    meta_t            s1_meta_reg, s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic [PIX_W-1:0] s1_pix_reg;

    logic [CSUM_W-1:0] cs0_reg, cs1_reg, cs2_reg, new_col;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [BLUR_W-1:0] value_reg;
    logic [2:0]        inflight;
    logic [QCW:0]      occupancy;

    // Admission: the queue must have room for everything already in flight.
    assign inflight  = 3'(s1_v_reg) + 3'(s2_v_reg) + 3'(s3_v_reg) + 3'(s4_v_reg);
    assign occupancy = (QCW + 1)'(q_count) + (QCW + 1)'(inflight);
    assign full      = occupancy >= (QCW + 1)'(QDEPTH);
    assign accept    = push && !full;

    // Classify the incoming pixel by its place in the frame.
    always_comb
    begin
        row_end   = col_reg >= wm1;
        frame_end = row_reg >= hm1;
        cls.row   = row_reg;
        cls.col   = col_reg;
        cls.mask[RES_DIAG]  = (row_reg != '0) && (col_reg != '0);
        cls.mask[RES_ABOVE] = (row_reg != '0) && row_end;
        cls.mask[RES_LEFT]  = frame_end && (col_reg != '0);
        cls.mask[RES_HERE]  = frame_end && row_end;
        cls.interior = (row_reg >= ROW_W'(2)) && (row_reg <= hm1) &&
                       (col_reg >= COL_W'(2)) && (col_reg <= wm1);
        col_next = row_end ? '0 : col_reg + 1'b1;
        row_next = row_end ? (frame_end ? '0 : row_reg + 1'b1) : row_reg;
    end

    // Raster position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line store read on acceptance, written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[AW'(col_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            line_mem[AW'(s1_meta_reg.col)] <= {rd_data_reg[PIX_W-1:0], s1_pix_reg};
        end
    end

    // Valid bits of the front pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_meta_reg <= cls;
        s1_pix_reg  <= pixel;
        s2_meta_reg <= s1_meta_reg;
        s3_meta_reg <= s2_meta_reg;
        s4_meta_reg <= s3_meta_reg;
    end

    // Window held as three column sums; the newest column enters on the right.
    assign new_col = CSUM_W'(rd_data_reg[2*PIX_W-1:PIX_W]) +
                     CSUM_W'(rd_data_reg[PIX_W-1:0]) + CSUM_W'(s1_pix_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs0_reg <= '0;
            cs1_reg <= '0;
            cs2_reg <= '0;
        end
        else if (s1_v_reg)
        begin
            cs0_reg <= cs1_reg;
            cs1_reg <= cs2_reg;
            cs2_reg <= new_col;
        end
    end

    // Window sum, then division by 25 as a multiply by the reciprocal.
    assign prod = SUM_W'(sum_reg) * RECIP;

    always_ff @(posedge clk)
    begin
        sum_reg   <= SUM_W'(cs0_reg) + SUM_W'(cs1_reg) + SUM_W'(cs2_reg);
        value_reg <= s3_meta_reg.interior ? prod[RECIP_SHIFT +: BLUR_W] : '0;
    end

    // Hand the job to the queue unless the pixel causes no result.
    assign job_push   = s4_v_reg && (s4_meta_reg.mask != '0);
    assign job.value  = value_reg;
    assign job.row    = s4_meta_reg.row;
    assign job.col    = s4_meta_reg.col;
    assign job.mask   = s4_meta_reg.mask;

endmodule

// ----- rtl/bb3_queue.sv -----
// Short job queue between the front and back parts.
module bb3_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  bb3_pkg::bb3_job_t       wr_job,
    input  logic                    rd_en,
    output bb3_pkg::bb3_job_t       rd_job,
    output logic                    rd_valid,
    output logic [bb3_pkg::QCW-1:0] count
);
    import bb3_pkg::*;

    bb3_job_t         slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign rd_job   = slot_reg[rd_ptr_reg];
    assign rd_valid = count_reg != '0;
    assign count    = count_reg;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCW'(wr_en) - QCW'(rd_en);
        end
    end

endmodule

// ----- rtl/bb3_back.sv -----
// Back part: expands each job into its result requests and holds the output register.
module bb3_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bb3_pkg::bb3_job_t           job,
    input  logic                        job_valid,
    output logic                        job_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [bb3_pkg::BLUR_W-1:0]  blurred,
    output logic [bb3_pkg::ROW_W-1:0]   out_row,
    output logic [bb3_pkg::COL_W-1:0]   out_col,
    output logic                        run_last,
    output logic                        frame_last
);
    import bb3_pkg::*;

    bb3_job_t         cur_reg;
    logic [RES_N-1:0] rem_reg, rem_next, sel, rem_after;
    logic             active, out_free, emit, finishing;

    logic              out_v_reg;
    logic [BLUR_W-1:0] blur_reg, blur_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              run_last_reg, frame_last_reg, frame_last_next;

    // Pick the next result of the current job in emission order.
    always_comb
    begin
        sel = '0;
        priority if (rem_reg[RES_DIAG])  sel[RES_DIAG]  = 1'b1;
        else if (rem_reg[RES_ABOVE])     sel[RES_ABOVE] = 1'b1;
        else if (rem_reg[RES_LEFT])      sel[RES_LEFT]  = 1'b1;
        else if (rem_reg[RES_HERE])      sel[RES_HERE]  = 1'b1;
        else                             sel = '0;
    end

    assign active    = rem_reg != '0;
    assign out_free  = !out_v_reg || pop;
    assign emit      = active && out_free;
    assign rem_after = rem_reg & ~sel;
    assign finishing = emit && (rem_after == '0);
    assign job_pop   = job_valid && (!active || finishing);

    always_comb
    begin
        if (job_pop)
        begin
            rem_next = job.mask;
        end
        else if (emit)
        begin
            rem_next = rem_after;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    // Payload of the selected result.
    always_comb
    begin
        blur_next       = '0;
        row_next        = cur_reg.row;
        col_next        = cur_reg.col;
        frame_last_next = 1'b0;
        if (sel[RES_DIAG])
        begin
            blur_next = cur_reg.value;
            row_next  = cur_reg.row - 1'b1;
            col_next  = cur_reg.col - 1'b1;
        end
        else if (sel[RES_ABOVE])
        begin
            row_next = cur_reg.row - 1'b1;
        end
        else if (sel[RES_LEFT])
        begin
            col_next = cur_reg.col - 1'b1;
        end
        else
        begin
            frame_last_next = 1'b1;
        end
    end

    // Current job.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            blur_reg       <= blur_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            run_last_reg   <= rem_after == '0;
            frame_last_reg <= frame_last_next;
        end
    end

    assign empty      = !out_v_reg;
    assign blurred    = blur_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign run_last   = run_last_reg;
    assign frame_last = frame_last_reg;

endmodule

// ----- rtl/box_blur_3x3_stream.sv -----
// Top level of the 3x3 box blur stream: configuration registers and the three parts.
//
// Grey pixels enter in raster order through push/full and filtered pixels leave
// through empty/pop, each carrying its row, column, a marker on the last result
// of its source pixel and a marker on the last pixel of the frame. A pixel is
// accepted every clock while the job queue has room; a result leaves every clock
// from the single output register while pop is held. Most pixels cause one
// result and those of the first row or column none; a later pixel that ends a
// row causes two, and each pixel of the last row but its first causes two (the
// pixel closing the frame four), so along the last row the input is paced by
// the one-result-per-clock back part. Image width and height are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT on writing; write them only while the block is
// idle. The line store needs no clearing after reset; only if the width is
// raised mid-frame can an interior result read a never-written entry, and its
// value is then undefined.
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bb3_pkg::PIX_W-1:0]      pixel,
    output logic                           empty,
    input  logic                           pop,
    output logic [bb3_pkg::BLUR_W-1:0]     blurred,
    output logic [bb3_pkg::ROW_W-1:0]      out_row,
    output logic [bb3_pkg::COL_W-1:0]      out_col,
    output logic                           run_last,
    output logic                           frame_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bb3_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    logic [WW-1:0]         wm1_reg, wm1_next;
    logic [HW-1:0]         hm1_reg, hm1_next;
    logic [IMG_W_BITS-1:0] cfg_w;
    logic [IMG_H_BITS-1:0] cfg_h;
    logic [WW-1:0]         wm1_clamped;
    logic [HW-1:0]         hm1_clamped;

    bb3_job_t       fe_job, q_job;
    logic           fe_push, q_valid, q_pop;
    logic [QCW-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign cfg_w     = cfg_data[IMG_W_BITS-1:0];
    assign cfg_h     = cfg_data[IMG_H_BITS-1:0];

    // Clamp written dimensions and keep them as last index (size minus one).
    always_comb
    begin
        if (cfg_w < IMG_W_BITS'(3))
        begin
            wm1_clamped = WW'(2);
        end
        else if (cfg_w > MAX_WIDTH)
        begin
            wm1_clamped = WW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1_clamped = WW'(cfg_w - 1'b1);
        end

        if (cfg_h < IMG_H_BITS'(3))
        begin
            hm1_clamped = HW'(2);
        end
        else if (cfg_h > MAX_HEIGHT)
        begin
            hm1_clamped = HW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1_clamped = HW'(cfg_h - 1'b1);
        end
    end

    // Register write decode.
    always_comb
    begin
        wm1_next = wm1_reg;
        hm1_next = hm1_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (bb3_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  wm1_next = wm1_clamped;
                REG_IMAGE_HEIGHT: hm1_next = hm1_clamped;
                default:          wm1_next = wm1_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg <= WW'(RST_W - 1);
            hm1_reg <= HW'(RST_H - 1);
        end
        else
        begin
            wm1_reg <= wm1_next;
            hm1_reg <= hm1_next;
        end
    end

    // Front part: admission, line store, window and arithmetic.
    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pixel    (pixel),
        .full     (full),
        .wm1      (wm1_reg),
        .hm1      (hm1_reg),
        .q_count  (q_count),
        .job_push (fe_push),
        .job      (fe_job)
    );

    // Job queue.
    bb3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fe_push),
        .wr_job   (fe_job),
        .rd_en    (q_pop),
        .rd_job   (q_job),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    // Back part: result expansion and output register.
    bb3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (q_job),
        .job_valid  (q_valid),
        .job_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .blurred    (blurred),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

endmodule
